/* rtl/ndf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndf_pkg: shared types and helpers for the nonce duplicate filter
// Holds the stored-entry layout, the command and status groups between the
// controller and the datapath, and the nonce masking helper.
// ----------------------------------------------------------------------------
package ndf_pkg;

	localparam int NDF_DEFAULT_ENTRIES = 64;
	localparam int NONCE_BYTES         = 8;
	localparam int NONCE_W             = 8 * NONCE_BYTES;
	localparam int LENGTH_W            = 4;

	// One stored nonce: its length and its bytes masked to that length.
	typedef struct packed {
		logic [LENGTH_W-1:0] len;
		logic [NONCE_W-1:0]  value;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the incoming word and clear the hit flag
		logic issue;  // read the next stored entry for comparison
		logic write;  // store the captured nonce as the newest entry
	} ndf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flag;        // captured word carries a nonce
		logic empty;       // no entry is stored yet
		logic last_issue;  // the read being issued is the last valid entry
		logic hit;         // a matching entry has been found
	} ndf_status_t;

	// Keep only the bytes below the given length; lengths of eight or more
	// keep all bytes.
	function automatic logic [NONCE_W-1:0] mask_nonce(
		input logic [NONCE_W-1:0]  value,
		input logic [LENGTH_W-1:0] len
	);
		logic [NONCE_W-1:0] res;
		res = '0;
		for (int b = 0; b < NONCE_BYTES; b++) begin
			if (len > LENGTH_W'(b)) begin
				res[8*b +: 8] = value[8*b +: 8];
			end
		end
		return res;
	endfunction

endpackage

/* rtl/ndf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndf_datapath: nonce store and compare path
// Holds the ring of stored nonces, the fill count and write pointer, and
// compares one stored entry per cycle against the captured nonce.
// ----------------------------------------------------------------------------
module ndf_datapath #(
	parameter int NONCE_ENTRIES = ndf_pkg::NDF_DEFAULT_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ndf_pkg::ndf_cmd_t             cmd,
	output ndf_pkg::ndf_status_t          status,
	input  logic                          checks_nonce,
	input  logic [ndf_pkg::NONCE_W-1:0]   nonce_value,
	input  logic [ndf_pkg::LENGTH_W-1:0]  nonce_length,
	output logic                          is_duplicate
);
	import ndf_pkg::*;

	localparam int AW = (NONCE_ENTRIES > 1) ? $clog2(NONCE_ENTRIES) : 1;
	localparam int CW = $clog2(NONCE_ENTRIES + 1);

	entry_t mem [NONCE_ENTRIES];

	entry_t          key_q;
	logic            flag_q;
	logic            hit_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   wr_ptr_q;
	logic [CW-1:0]   count_q;
	entry_t          rd_data_s1;
	logic            rd_vld_s1;

	// Memory write and registered read; the two never happen in one cycle.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_ptr_q] <= key_q;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q.len   <= nonce_length;
			key_q.value <= mask_nonce(nonce_value, nonce_length);
			flag_q      <= checks_nonce;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			idx_q     <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				hit_q <= 1'b0;
				idx_q <= '0;
			end else begin
				if (rd_vld_s1 && (rd_data_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (cmd.issue) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			if (cmd.write) begin
				if (wr_ptr_q == AW'(NONCE_ENTRIES - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + AW'(1);
				end
				if (count_q != CW'(NONCE_ENTRIES)) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// Entries fill in ring order, so slot k is valid exactly when k < count.
	assign status.flag       = flag_q;
	assign status.empty      = (count_q == '0);
	assign status.last_issue = ((CW'(idx_q) + CW'(1)) == count_q);
	assign status.hit        = hit_q;

	assign is_duplicate = hit_q;

endmodule

/* rtl/ndf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndf_ctrl: sequencing controller for the nonce duplicate filter
// Accepts a word, walks the stored entries, decides between duplicate and
// store, and strobes the result.
// ----------------------------------------------------------------------------
module ndf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output ndf_pkg::ndf_cmd_t     cmd,
	input  ndf_pkg::ndf_status_t  status
);
	import ndf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESOLVE,
		ST_WRITE,
		ST_REPORT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (!status.flag) begin
						state_q <= ST_REPORT;
					end else if (status.empty) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:   state_q <= ST_RESOLVE;
				ST_RESOLVE: state_q <= status.hit ? ST_REPORT : ST_WRITE;
				ST_WRITE:   state_q <= ST_REPORT;
				ST_REPORT:  state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_REPORT);
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.issue = (state_q == ST_SCAN);
	assign cmd.write = (state_q == ST_WRITE);

endmodule

/* rtl/nonce_duplicate_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_duplicate_filter: duplicate detection for packet nonces
// Keeps the most recent NONCE_ENTRIES distinct nonces and flags repeats.
// ----------------------------------------------------------------------------
// Usage:
// A word (checks_nonce, nonce_value, nonce_length) is taken at a rising edge
// where start is high and busy is low. Exactly one result follows: done is
// high for one cycle with is_duplicate valid beside it; the receiver cannot
// hold it off. busy stays high through the done cycle and falls right after
// it, so a new word is taken only once busy is low again.
// Path from the accepting edge to the done cycle:
//   nonce not checked:              straight to the result
//   store empty (nonce is stored):  the nonce is stored first
//   otherwise:                      every stored entry is scanned (at most
//                                   NONCE_ENTRIES), then on a miss the
//                                   nonce is stored.
// The nonce memory has a single read port: the stored entries are read and
// compared one per cycle. Reset (arst_n low) empties the store by clearing
// its fill count, so the block is ready at once.
// ----------------------------------------------------------------------------
module nonce_duplicate_filter #(
	parameter int NONCE_ENTRIES = ndf_pkg::NDF_DEFAULT_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          checks_nonce,
	input  logic [ndf_pkg::NONCE_W-1:0]   nonce_value,
	input  logic [ndf_pkg::LENGTH_W-1:0]  nonce_length,
	output logic                          done,
	output logic                          is_duplicate
);
	import ndf_pkg::*;

	ndf_cmd_t    cmd;
	ndf_status_t status;

	// The controller sequences each word: capture, scan, decide, store.
	ndf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// The datapath holds the ring of nonces and the running hit flag; the
	// hit flag stays cleared for words that carry no nonce.
	ndf_datapath #(
		.NONCE_ENTRIES (NONCE_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.checks_nonce (checks_nonce),
		.nonce_value  (nonce_value),
		.nonce_length (nonce_length),
		.is_duplicate (is_duplicate)
	);

endmodule

/* test/nonce_duplicate_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_duplicate_filter_tb: self-checking bench for the nonce duplicate filter
// Sends directed and random nonce words through the start/busy command port and
// compares every is_duplicate verdict with a scoreboard that keeps its own copy
// of the recent-nonce ring, including masking, odd lengths and ring overwrite.
// ----------------------------------------------------------------------------

// Scoreboard: holds the expected contents of the nonce ring and the verdicts
// still owed by the block, oldest first.
class nonce_ring_scoreboard;

	logic [ndf_pkg::NONCE_W-1:0]  slot_value [ndf_pkg::NDF_DEFAULT_ENTRIES];
	logic [ndf_pkg::LENGTH_W-1:0] slot_len   [ndf_pkg::NDF_DEFAULT_ENTRIES];
	bit                           slot_used  [ndf_pkg::NDF_DEFAULT_ENTRIES];
	int unsigned                  next_slot;
	bit                           owed_verdicts [$];
	int unsigned                  mismatches;

	function new();
		for (int i = 0; i < ndf_pkg::NDF_DEFAULT_ENTRIES; i++) begin
			slot_value[i] = '0;
			slot_len[i]   = '0;
			slot_used[i]  = 1'b0;
		end
		next_slot  = 0;
		mismatches = 0;
	endfunction

	// Bytes at or above the length are dropped; eight or more keeps all.
	function logic [ndf_pkg::NONCE_W-1:0] keep_bytes(
		input logic [ndf_pkg::NONCE_W-1:0]  value,
		input logic [ndf_pkg::LENGTH_W-1:0] len
	);
		logic [ndf_pkg::NONCE_W-1:0] keep;
		if (len >= 8)
			keep = '1;
		else if (len == 0)
			keep = '0;
		else
			keep = (64'd1 << (8 * len)) - 64'd1;
		return value & keep;
	endfunction

	// Called for every word the block takes in.
	function void note_word(
		input bit                           flag,
		input logic [ndf_pkg::NONCE_W-1:0]  value,
		input logic [ndf_pkg::LENGTH_W-1:0] len
	);
		logic [ndf_pkg::NONCE_W-1:0] masked;
		bit                          hit;
		masked = keep_bytes(value, len);
		hit    = 1'b0;
		if (!flag) begin
			owed_verdicts.push_back(1'b0);
			return;
		end
		for (int i = 0; i < ndf_pkg::NDF_DEFAULT_ENTRIES; i++) begin
			if (slot_used[i] && slot_len[i] == len && slot_value[i] == masked)
				hit = 1'b1;
		end
		if (!hit) begin
			slot_value[next_slot] = masked;
			slot_len[next_slot]   = len;
			slot_used[next_slot]  = 1'b1;
			next_slot = (next_slot + 1) % ndf_pkg::NDF_DEFAULT_ENTRIES;
		end
		owed_verdicts.push_back(hit);
	endfunction

	// Called for every done strobe.
	function void check_verdict(input logic actual);
		bit wanted;
		if (owed_verdicts.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual is_duplicate=%b",
				$time, actual);
			mismatches++;
			return;
		end
		wanted = owed_verdicts.pop_front();
		if (actual !== wanted) begin
			$display("%0t: is_duplicate mismatch, expected %b, actual %b",
				$time, wanted, actual);
			mismatches++;
		end
	endfunction

	function int unsigned owed_count();
		return owed_verdicts.size();
	endfunction

endclass

module nonce_duplicate_filter_tb;

	typedef struct {
		logic [ndf_pkg::NONCE_W-1:0]  value;
		logic [ndf_pkg::LENGTH_W-1:0] len;
	} nonce_word_t;

	// Every input has a known value from time zero; reset is held from the start.
	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           start        = 1'b0;
	logic                           checks_nonce = 1'b0;
	logic [ndf_pkg::NONCE_W-1:0]    nonce_value  = '0;
	logic [ndf_pkg::LENGTH_W-1:0]   nonce_length = '0;
	logic                           busy;
	logic                           done;
	logic                           is_duplicate;

	// Percentage of words that are preceded by a hold-off on the sending side.
	int unsigned sender_idle_pct = 0;

	nonce_ring_scoreboard nonce_history = new();

	// Nonces sent recently with the flag set. The pool is about twice the ring
	// depth, so a repeat drawn from it is sometimes still stored and sometimes
	// already pushed out by newer entries.
	nonce_word_t recent_words [$];

	nonce_duplicate_filter #(
		.NONCE_ENTRIES(ndf_pkg::NDF_DEFAULT_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.checks_nonce(checks_nonce),
		.nonce_value(nonce_value),
		.nonce_length(nonce_length),
		.done(done),
		.is_duplicate(is_duplicate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results cannot be held off, so every done strobe is checked right away.
	always @(posedge clk) begin
		if (arst_n && done)
			nonce_history.check_verdict(is_duplicate);
	end

	// Entered and left at a falling edge. Start stays high from one word to the
	// next unless a hold-off is drawn, so it never gets two updates in one step.
	task automatic send_word(
		input bit                           flag,
		input logic [ndf_pkg::NONCE_W-1:0]  value,
		input logic [ndf_pkg::LENGTH_W-1:0] len
	);
		int unsigned gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			// Mostly short gaps; now and then one long enough to span a whole
			// search, so the restart falls on varied points of the busy period.
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		checks_nonce <= flag;
		nonce_value  <= value;
		nonce_length <= len;
		do
			@(posedge clk);
		while (busy);
		nonce_history.note_word(flag, value, len);
		@(negedge clk);
	endtask

	// Sends one word and remembers flagged nonces for later repeats.
	task automatic send_and_remember(
		input bit                           flag,
		input logic [ndf_pkg::NONCE_W-1:0]  value,
		input logic [ndf_pkg::LENGTH_W-1:0] len
	);
		nonce_word_t w;
		send_word(flag, value, len);
		if (flag) begin
			w.value = value;
			w.len   = len;
			recent_words.push_back(w);
			if (recent_words.size() > 128)
				void'(recent_words.pop_front());
		end
	endtask

	initial begin
		int unsigned                 phase_idle [3];
		int unsigned                 roll;
		int unsigned                 idx;
		int unsigned                 len_roll;
		bit                          flag;
		nonce_word_t                 w;
		logic [ndf_pkg::NONCE_W-1:0] stray;
		logic [ndf_pkg::NONCE_W-1:0] big;

		phase_idle[0] = 33;
		phase_idle[1] = 59;
		phase_idle[2] = 0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		big = {$urandom, $urandom};

		// Directed words. A clear flag must neither report a duplicate nor
		// store anything, so the same nonce flagged afterwards is a miss.
		send_and_remember(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_and_remember(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_and_remember(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_and_remember(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		// A zero-length nonce has no bytes, so any value matches another one.
		send_and_remember(1'b1, 64'h0123_4567_89AB_CDEF, 4'd0);
		send_and_remember(1'b1, 64'hFEDC_BA98_7654_3210, 4'd0);
		// Stray bytes above the length are ignored before compare and store.
		send_and_remember(1'b1, 64'hDEAD_BEEF_0000_00AB, 4'd1);
		send_and_remember(1'b1, 64'h0000_0000_0000_00AB, 4'd1);
		send_and_remember(1'b1, 64'h5555_5555_5555_55AB, 4'd1);
		// Same bytes with a different length never match.
		send_and_remember(1'b1, 64'h0000_0000_0000_00AB, 4'd2);
		send_and_remember(1'b1, 64'h0000_0000_0000_0000, 4'd1);
		send_and_remember(1'b1, 64'h0000_0000_0000_0000, 4'd8);
		// Lengths above eight keep all eight bytes but the length must match.
		send_and_remember(1'b1, big, 4'd9);
		send_and_remember(1'b1, big, 4'd9);
		send_and_remember(1'b1, big, 4'd15);
		send_and_remember(1'b1, big, 4'd8);
		send_and_remember(1'b1, big, 4'd15);
		send_and_remember(1'b1, 64'hAAAA_AAAA_FFFF_FFFF, 4'd4);
		send_and_remember(1'b1, 64'h0000_0000_FFFF_FFFF, 4'd4);
		send_and_remember(1'b1, 64'h0000_FFFF_FFFF_FFFF, 4'd5);
		send_and_remember(1'b1, 64'h5A5A_5A5A_5A5A_5A5A, 4'd7);
		send_and_remember(1'b1, 64'h005A_5A5A_5A5A_5A5A, 4'd7);

		// Random words in three phases of sender idling. Well over the ring
		// depth of misses go by, so the oldest entry is overwritten many times.
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = phase_idle[phase];
			repeat (150) begin
				roll = $urandom_range(99);
				flag = 1'b1;
				if (roll < 8) begin
					flag     = 1'b0;
					w.value  = {$urandom, $urandom};
					w.len    = 4'($urandom_range(15));
				end else if (roll < 50 && recent_words.size() > 0) begin
					// Repeat of a recent nonce, sometimes with new junk above it.
					idx = $urandom_range(recent_words.size() - 1);
					w   = recent_words[idx];
					if ($urandom_range(3) == 0 && w.len < 8) begin
						stray   = {$urandom, $urandom};
						w.value = nonce_history.keep_bytes(w.value, w.len) |
							(stray & ~nonce_history.keep_bytes('1, w.len));
					end
				end else begin
					len_roll = $urandom_range(19);
					if (len_roll < 16)
						w.len = 4'($urandom_range(1, 8));
					else if (len_roll < 18)
						w.len = 4'd0;
					else
						w.len = 4'($urandom_range(9, 15));
					// Tiny values make chance collisions between fresh nonces.
					if ($urandom_range(4) == 0)
						w.value = 64'($urandom_range(3));
					else
						w.value = {$urandom, $urandom};
				end
				send_and_remember(flag, w.value, w.len);
			end
		end

		start <= 1'b0;

		// Drain the owed verdicts, then watch a little longer than the longest
		// search for any stray done strobe.
		while (nonce_history.owed_count() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (nonce_history.mismatches == 0 && nonce_history.owed_count() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of this stimulus.
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
